### src/assert_macros.svh
// Assertion macros included by the top-level classifier file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define CDSC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CDSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/cdsc_pkg.sv
// Types and constants of the CD sector classifier.
`timescale 1ns / 1ps

package cdsc_pkg;

	localparam int SECTOR_BYTES_DEF = 2352;

	localparam int LEN_W   = 12;
	localparam int START_W = 5;
	localparam int SUB_W   = 32;
	localparam int WIN_W   = 3;
	localparam int WIN_COUNT = 5;

	localparam int SYNC_LEN  = 12;
	localparam int SYNC_LAST = 11;
	localparam int MODE_POS  = 15;
	localparam int SUB_POS   = 16;
	localparam int FORM2_POS = 18;
	localparam int SUB2_POS  = 20;
	localparam int SUB_END   = 24;
	localparam int FORM2_BIT = 5;

	localparam logic [7:0] MODE_ONE = 8'd1;
	localparam logic [7:0] MODE_TWO = 8'd2;

	typedef logic [WIN_W-1:0] win_t;
	localparam win_t WIN_AUDIO = 3'd0;
	localparam win_t WIN_M1    = 3'd1;
	localparam win_t WIN_M2    = 3'd2;
	localparam win_t WIN_F1    = 3'd3;
	localparam win_t WIN_F2    = 3'd4;

	// Window bounds; the audio window upper bound follows the sector size.
	localparam int WIN_LO [WIN_COUNT] = '{0, 16, 16, 24, 24};
	localparam int WIN_HI [WIN_COUNT] = '{0, 16 + 2048, 16 + 2336, 24 + 2048, 24 + 2324};
	localparam logic [LEN_W-1:0] WIN_LEN [WIN_COUNT] =
		'{12'd0, 12'd2048, 12'd2336, 12'd2048, 12'd2324};
	localparam logic [START_W-1:0] WIN_START [WIN_COUNT] =
		'{5'd0, 5'd16, 5'd16, 5'd24, 5'd24};

	typedef enum logic [2:0] {
		KIND_ZERO    = 3'd0,
		KIND_AUDIO   = 3'd1,
		KIND_MODE1   = 3'd2,
		KIND_MODE2   = 3'd3,
		KIND_FORM1   = 3'd4,
		KIND_FORM2   = 3'd5,
		KIND_INVALID = 3'd6
	} kind_t;

	typedef struct packed {
		logic                              sync;
		logic [7:0]                        mode;
		logic [SUB_W-1:0]                  sub;
		logic                              sub_eq;
		logic                              form2;
		logic                              any_nz;
		logic [WIN_COUNT-1:0][LEN_W-1:0]   lnz;
	} sec_state_t;

	localparam sec_state_t SEC_CLEAR = '{
		sync:   1'b1,
		mode:   8'd0,
		sub:    '0,
		sub_eq: 1'b1,
		form2:  1'b0,
		any_nz: 1'b0,
		lnz:    '0
	};

endpackage

### src/cdsc_if.sv
// Valid/ready channel interfaces for sector bytes and classification results.
`timescale 1ns / 1ps

interface cdsc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] sector_byte;

	modport source (output valid, output sector_byte, input ready);
	modport sink (input valid, input sector_byte, output ready);
endinterface

interface cdsc_res_if;
	logic                             valid;
	logic                             ready;
	logic [2:0]                       sector_kind;
	logic [cdsc_pkg::START_W-1:0]     payload_start;
	logic [cdsc_pkg::LEN_W-1:0]       payload_length;
	logic                             was_trimmed;
	logic [cdsc_pkg::SUB_W-1:0]       subheader_word;

	modport source (output valid, output sector_kind, output payload_start,
		output payload_length, output was_trimmed, output subheader_word, input ready);
	modport sink (input valid, input sector_kind, input payload_start,
		input payload_length, input was_trimmed, input subheader_word, output ready);
endinterface

### src/cdsc_track.sv
// Per-byte sector tracker: position, sync, header, subheader and window state.
`timescale 1ns / 1ps

module cdsc_track #(
	parameter int SECTOR_BYTES = cdsc_pkg::SECTOR_BYTES_DEF,
	localparam int POS_W = $clog2(SECTOR_BYTES)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            b,
	input  logic                  fire,
	output logic [POS_W-1:0]      pos,
	output logic                  last,
	output cdsc_pkg::sec_state_t  nxt
);

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(SECTOR_BYTES - 1);

	logic [POS_W-1:0]     pos_q;
	cdsc_pkg::sec_state_t state_q;
	logic [7:0]           expect_b;
	logic [POS_W:0]       pos_x;

	assign pos  = pos_q;
	assign last = (pos_q == LAST_POS);
	assign pos_x = {1'b0, pos_q};

	always_comb begin
		nxt = state_q;
		expect_b = ((pos_q == POS_W'(0)) || (pos_q == POS_W'(cdsc_pkg::SYNC_LAST))) ?
			8'h00 : 8'hFF;
		if ((pos_q < POS_W'(cdsc_pkg::SYNC_LEN)) && (b != expect_b)) begin
			nxt.sync = 1'b0;
		end
		if (pos_q == POS_W'(cdsc_pkg::MODE_POS)) begin
			nxt.mode = b;
		end
		if ((pos_q >= POS_W'(cdsc_pkg::SUB_POS)) && (pos_q < POS_W'(cdsc_pkg::SUB2_POS))) begin
			nxt.sub[{pos_q[1:0], 3'b000} +: 8] = b;
		end
		if (pos_q == POS_W'(cdsc_pkg::FORM2_POS)) begin
			nxt.form2 = b[cdsc_pkg::FORM2_BIT];
		end
		if ((pos_q >= POS_W'(cdsc_pkg::SUB2_POS)) && (pos_q < POS_W'(cdsc_pkg::SUB_END))) begin
			if (state_q.sub[{pos_q[1:0], 3'b000} +: 8] != b) begin
				nxt.sub_eq = 1'b0;
			end
		end
		if (b != 8'h00) begin
			nxt.any_nz = 1'b1;
			for (int w = 0; w < cdsc_pkg::WIN_COUNT; w++) begin
				if ((pos_x >= (POS_W+1)'(cdsc_pkg::WIN_LO[w])) &&
				    (pos_x < (POS_W+1)'((w == 0) ? SECTOR_BYTES : cdsc_pkg::WIN_HI[w]))) begin
					nxt.lnz[w] = cdsc_pkg::LEN_W'(pos_x - (POS_W+1)'(cdsc_pkg::WIN_LO[w])
						+ (POS_W+1)'(1));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			state_q <= cdsc_pkg::SEC_CLEAR;
		end else if (fire) begin
			if (last) begin
				pos_q   <= '0;
				state_q <= cdsc_pkg::SEC_CLEAR;
			end else begin
				pos_q   <= pos_q + POS_W'(1);
				state_q <= nxt;
			end
		end
	end

endmodule

### src/cdsc_class.sv
// Sector classification and result register.
`timescale 1ns / 1ps

module cdsc_class #(
	parameter int SECTOR_BYTES = cdsc_pkg::SECTOR_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cdsc_pkg::sec_state_t nxt,
	input  logic                 trim,
	input  logic                 load,
	output logic                 slot_free,
	cdsc_res_if.source           result
);

	cdsc_pkg::kind_t                 kind;
	cdsc_pkg::win_t                  win;
	logic                            has_win;
	logic [cdsc_pkg::SUB_W-1:0]      sub;
	logic [cdsc_pkg::LEN_W-1:0]      nominal;
	logic [cdsc_pkg::LEN_W-1:0]      len;
	logic [cdsc_pkg::START_W-1:0]    start;
	logic                            trimmed;

	logic                            valid_q;
	cdsc_pkg::kind_t                 kind_q;
	logic [cdsc_pkg::START_W-1:0]    start_q;
	logic [cdsc_pkg::LEN_W-1:0]      len_q;
	logic                            trimmed_q;
	logic [cdsc_pkg::SUB_W-1:0]      sub_q;

	always_comb begin
		kind    = cdsc_pkg::KIND_ZERO;
		win     = cdsc_pkg::WIN_AUDIO;
		has_win = 1'b0;
		sub     = '0;
		if (nxt.sync) begin
			if (nxt.mode == cdsc_pkg::MODE_ONE) begin
				kind    = cdsc_pkg::KIND_MODE1;
				win     = cdsc_pkg::WIN_M1;
				has_win = 1'b1;
			end else if (nxt.mode == cdsc_pkg::MODE_TWO) begin
				has_win = 1'b1;
				if (nxt.sub_eq) begin
					sub = nxt.sub;
					if (nxt.form2) begin
						kind = cdsc_pkg::KIND_FORM2;
						win  = cdsc_pkg::WIN_F2;
					end else begin
						kind = cdsc_pkg::KIND_FORM1;
						win  = cdsc_pkg::WIN_F1;
					end
				end else begin
					kind = cdsc_pkg::KIND_MODE2;
					win  = cdsc_pkg::WIN_M2;
				end
			end else begin
				kind = cdsc_pkg::KIND_INVALID;
			end
		end else if (nxt.any_nz) begin
			kind    = cdsc_pkg::KIND_AUDIO;
			win     = cdsc_pkg::WIN_AUDIO;
			has_win = 1'b1;
		end

		nominal = (win == cdsc_pkg::WIN_AUDIO) ? cdsc_pkg::LEN_W'(SECTOR_BYTES) :
			cdsc_pkg::WIN_LEN[win];
		if (has_win) begin
			start   = cdsc_pkg::WIN_START[win];
			len     = trim ? nxt.lnz[win] : nominal;
			trimmed = (len != nominal);
		end else begin
			start   = '0;
			len     = '0;
			trimmed = 1'b0;
		end
	end

	assign slot_free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q    <= kind;
			start_q   <= start;
			len_q     <= len;
			trimmed_q <= trimmed;
			sub_q     <= sub;
		end
	end

	assign result.valid          = valid_q;
	assign result.sector_kind    = kind_q;
	assign result.payload_start  = start_q;
	assign result.payload_length = len_q;
	assign result.was_trimmed    = trimmed_q;
	assign result.subheader_word = sub_q;

endmodule

### src/cd_sector_classifier_trimmer.sv
// A sector's result becomes valid when its final byte, held in the input register, loads the result register.
// Throughput: one byte per cycle; the input register stalls only when a final byte
// meets a result that has not been taken yet.
// Reset: arst_n clears the byte position, sector state, trim setting and valids.
// After each final byte the sector state returns to its cleared value.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cd_sector_classifier_trimmer #(
	parameter int SECTOR_BYTES = cdsc_pkg::SECTOR_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic         cfg_wr_data,
	cdsc_byte_if.sink    sector,
	cdsc_res_if.source   result
);

	localparam int POS_W = $clog2(SECTOR_BYTES);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 trim_q;
	logic                 last;
	logic                 slot_free;
	logic                 fire_s1;
	logic                 load;
	logic [POS_W-1:0]     pos;
	cdsc_pkg::sec_state_t nxt;

	assign fire_s1      = valid_s1 && (!last || slot_free);
	assign load         = fire_s1 && last;
	assign sector.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sector.valid && sector.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sector.valid && sector.ready) begin
			byte_s1 <= sector.sector_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_q <= 1'b0;
		end else if (cfg_wr_en) begin
			trim_q <= cfg_wr_data;
		end
	end

	cdsc_track #(.SECTOR_BYTES(SECTOR_BYTES)) u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.b      (byte_s1),
		.fire   (fire_s1),
		.pos    (pos),
		.last   (last),
		.nxt    (nxt)
	);

	cdsc_class #(.SECTOR_BYTES(SECTOR_BYTES)) u_class (
		.clk       (clk),
		.arst_n    (arst_n),
		.nxt       (nxt),
		.trim      (trim_q),
		.load      (load),
		.slot_free (slot_free),
		.result    (result)
	);

	`CDSC_ASSERT(a_result_from_last, clk, arst_n, $rose(result.valid) |-> $past(load), "result without final byte")
	`CDSC_ASSERT(a_pos_wraps, clk, arst_n, $past(load) |-> (pos == '0), "position not cleared after sector")
	`CDSC_ASSERT(a_last_stalls, clk, arst_n, (valid_s1 && last && !slot_free) |-> !sector.ready, "final byte not held while result pending")

endmodule

### sim/tb_top.sv
// Testbench for the CD sector classifier: whole sectors in, one classification checked per sector.
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int LONG_HOLD   = 6000;
	localparam int SEC_N       = cdsc_pkg::SECTOR_BYTES_DEF;

	typedef struct packed {
		cdsc_pkg::kind_t              kind;
		logic [cdsc_pkg::START_W-1:0] start;
		logic [cdsc_pkg::LEN_W-1:0]   len;
		logic                         trimmed;
		logic [cdsc_pkg::SUB_W-1:0]   sub;
	} sector_verdict_t;

	typedef struct {
		bit              typed;
		sector_verdict_t want;
	} verdict_plan_t;

	typedef struct {
		bit              trim;
		bit              hdr;
		logic [7:0]      mode;
		logic [31:0]     sub_a;
		logic [31:0]     sub_b;
		int              lo;
		int              hi;
		logic [7:0]      fill;
		bit              typed;
		sector_verdict_t want;
	} sector_recipe_t;

	typedef struct {
		int src_idle;
		int sink_stall;
		bit trim;
		int sectors;
		bit hold;
	} phase_t;

	const int PAY_LO [cdsc_pkg::WIN_COUNT]  = '{0, 16, 16, 24, 24};
	const int PAY_LEN [cdsc_pkg::WIN_COUNT] = '{2352, 2048, 2336, 2048, 2324};
	const int TAIL_ENDS [4]                 = '{2064, 2072, 2348, 2352};

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;

	cdsc_byte_if byte_if ();
	cdsc_res_if  res_if ();

	cd_sector_classifier_trimmer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.sector      (byte_if),
		.result      (res_if)
	);

	// sector tracking state
	int          pos = 0;
	bit          sync_ok = 1'b1;
	logic [7:0]  mode_seen = '0;
	logic [31:0] sub_first = '0;
	bit          subs_match = 1'b1;
	bit          form2_seen = 1'b0;
	bit          nz_seen = 1'b0;
	int          last_nz [cdsc_pkg::WIN_COUNT] = '{default: 0};
	bit          trim_on;

	sector_verdict_t verdict_q [$];
	verdict_plan_t   plan_q [$];
	logic [7:0]      sec_buf [SEC_N];
	sector_recipe_t  recipes [19];
	phase_t          phases [6];

	int err_count = 0;
	int cycles = 0;
	int src_idle;
	int sink_stall;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic clear_tracking();
		int w;
		pos = 0;
		sync_ok = 1'b1;
		mode_seen = '0;
		sub_first = '0;
		subs_match = 1'b1;
		form2_seen = 1'b0;
		nz_seen = 1'b0;
		for (w = 0; w < cdsc_pkg::WIN_COUNT; w++) last_nz[w] = 0;
	endtask

	task automatic absorb_byte(input logic [7:0] b);
		int p;
		int w;
		int win;
		logic [7:0] sync_want;
		sector_verdict_t v;
		verdict_plan_t plan;
		p = pos;
		if (p < cdsc_pkg::SYNC_LEN) begin
			sync_want = (p == 0 || p == cdsc_pkg::SYNC_LAST) ? 8'h00 : 8'hFF;
			if (b != sync_want) sync_ok = 1'b0;
		end
		if (p == cdsc_pkg::MODE_POS) mode_seen = b;
		if (p >= cdsc_pkg::SUB_POS && p < cdsc_pkg::SUB2_POS)
			sub_first[8 * (p - cdsc_pkg::SUB_POS) +: 8] = b;
		if (p == cdsc_pkg::FORM2_POS) form2_seen = b[cdsc_pkg::FORM2_BIT];
		if (p >= cdsc_pkg::SUB2_POS && p < cdsc_pkg::SUB_END) begin
			if (sub_first[8 * (p - cdsc_pkg::SUB2_POS) +: 8] != b) subs_match = 1'b0;
		end
		if (b != 8'h00) begin
			nz_seen = 1'b1;
			for (w = 0; w < cdsc_pkg::WIN_COUNT; w++)
				if (p >= PAY_LO[w] && p < PAY_LO[w] + PAY_LEN[w]) last_nz[w] = p - PAY_LO[w] + 1;
		end
		if (p + 1 < SEC_N) begin
			pos = p + 1;
		end else begin
			v = '0;
			win = -1;
			if (sync_ok) begin
				if (mode_seen == cdsc_pkg::MODE_ONE) begin
					v.kind = cdsc_pkg::KIND_MODE1;
					win = cdsc_pkg::WIN_M1;
				end else if (mode_seen == cdsc_pkg::MODE_TWO) begin
					if (subs_match) begin
						v.kind = form2_seen ? cdsc_pkg::KIND_FORM2 : cdsc_pkg::KIND_FORM1;
						win = form2_seen ? cdsc_pkg::WIN_F2 : cdsc_pkg::WIN_F1;
						v.sub = sub_first;
					end else begin
						v.kind = cdsc_pkg::KIND_MODE2;
						win = cdsc_pkg::WIN_M2;
					end
				end else begin
					v.kind = cdsc_pkg::KIND_INVALID;
				end
			end else if (nz_seen) begin
				v.kind = cdsc_pkg::KIND_AUDIO;
				win = cdsc_pkg::WIN_AUDIO;
			end else begin
				v.kind = cdsc_pkg::KIND_ZERO;
			end
			if (win >= 0) begin
				v.start = cdsc_pkg::START_W'(PAY_LO[win]);
				v.len = trim_on ? cdsc_pkg::LEN_W'(last_nz[win]) : cdsc_pkg::LEN_W'(PAY_LEN[win]);
				v.trimmed = (int'(v.len) != PAY_LEN[win]);
			end
			plan.typed = 1'b0;
			plan.want = '0;
			if (plan_q.size() > 0) plan = plan_q.pop_front();
			verdict_q.push_back(plan.typed ? plan.want : v);
			clear_tracking();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %s: got 0x%0h, want 0x%0h (cycle %0d)", what, got, want, cycles);
		err_count++;
	endtask

	// input transfer monitor
	always @(posedge clk) begin
		if (arst_n && byte_if.valid && byte_if.ready) absorb_byte(byte_if.sector_byte);
	end

	// result transfer monitor
	always @(posedge clk) begin
		sector_verdict_t w;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (verdict_q.size() == 0) begin
				report_mismatch("unexpected result", {29'd0, res_if.sector_kind}, 32'd0);
			end else begin
				w = verdict_q.pop_front();
				if (res_if.sector_kind != w.kind)
					report_mismatch("sector_kind", 32'(res_if.sector_kind), 32'(w.kind));
				if (res_if.payload_start != w.start)
					report_mismatch("payload_start", 32'(res_if.payload_start), 32'(w.start));
				if (res_if.payload_length != w.len)
					report_mismatch("payload_length", 32'(res_if.payload_length), 32'(w.len));
				if (res_if.was_trimmed != w.trimmed)
					report_mismatch("was_trimmed", 32'(res_if.was_trimmed), 32'(w.trimmed));
				if (res_if.subheader_word != w.sub)
					report_mismatch("subheader_word", res_if.subheader_word, w.sub);
			end
		end
	end

	// result receiver with random stalls and an occasional long hold-off
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack = hold_req;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			res_if.ready <= 1'b0;
			hold_left--;
		end else begin
			res_if.ready <= ($urandom_range(0, 99) >= sink_stall);
		end
	end

	task automatic put_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < src_idle) begin
			byte_if.valid <= 1'b0;
			@(posedge clk);
		end
		byte_if.valid <= 1'b1;
		byte_if.sector_byte <= b;
		do @(posedge clk); while (!byte_if.ready);
	endtask

	task automatic send_sector();
		int i;
		for (i = 0; i < SEC_N; i++) put_byte(sec_buf[i]);
	endtask

	task automatic drain();
		byte_if.valid <= 1'b0;
		do @(posedge clk); while (verdict_q.size() != 0);
	endtask

	task automatic set_trim(input bit v);
		drain();
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		trim_on = v;
	endtask

	task automatic put_header(input logic [7:0] mode, input logic [31:0] sa,
		input logic [31:0] sb);
		int i;
		for (i = 0; i < cdsc_pkg::SYNC_LEN; i++)
			sec_buf[i] = (i == 0 || i == cdsc_pkg::SYNC_LAST) ? 8'h00 : 8'hFF;
		sec_buf[cdsc_pkg::MODE_POS] = mode;
		for (i = 0; i < 4; i++) begin
			sec_buf[cdsc_pkg::SUB_POS + i] = sa[8 * i +: 8];
			sec_buf[cdsc_pkg::SUB2_POS + i] = sb[8 * i +: 8];
		end
	endtask

	task automatic fill_random();
		int i;
		int cls;
		int e;
		int dens;
		int m;
		logic [7:0] mode;
		logic [31:0] sa;
		logic [31:0] sb;
		for (i = 0; i < SEC_N; i++) sec_buf[i] = 8'h00;
		cls = $urandom_range(0, 99);
		if (cls < 10) begin
			for (i = 0; i < SEC_N; i++) sec_buf[i] = 8'($urandom);
		end else if (cls < 20) begin
			if ($urandom_range(0, 1))
				sec_buf[$urandom_range(0, SEC_N - 1)] = 8'($urandom_range(1, 255));
		end else begin
			case ($urandom_range(0, 3))
				0: e = SEC_N;
				1: e = TAIL_ENDS[$urandom_range(0, 3)] + $urandom_range(0, 2) - 1;
				2: e = $urandom_range(12, SEC_N);
				default: e = $urandom_range(12, 100);
			endcase
			if (e > SEC_N) e = SEC_N;
			case ($urandom_range(0, 2))
				0: dens = 2;
				1: dens = 30;
				default: dens = 100;
			endcase
			for (i = 12; i < e; i++)
				if ($urandom_range(0, 99) < dens) sec_buf[i] = 8'($urandom_range(1, 255));
			if (e > 12) sec_buf[e - 1] = 8'($urandom_range(1, 255));
			m = $urandom_range(0, 99);
			if (m < 35) mode = cdsc_pkg::MODE_ONE;
			else if (m < 90) mode = cdsc_pkg::MODE_TWO;
			else mode = 8'($urandom);
			sa = $urandom;
			sb = ($urandom_range(0, 99) < 80) ? sa : sa ^ (32'h1 << $urandom_range(0, 31));
			put_header(mode, sa, sb);
			if (cls < 30)
				sec_buf[$urandom_range(0, cdsc_pkg::SYNC_LAST)] ^= 8'($urandom_range(1, 255));
		end
	endtask

	initial begin
		int r;
		int ph;
		int s;
		int i;
		verdict_plan_t plan;

		arst_n = 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 1'b0;
		byte_if.valid <= 1'b0;
		byte_if.sector_byte <= 8'h00;
		src_idle = 0;
		sink_stall = 0;
		trim_on = 1'b0;

		recipes = '{
			'{0, 0, 8'h00, 32'h0, 32'h0, 0, 0, 8'h00, 1,
				'{cdsc_pkg::KIND_ZERO, 5'd0, 12'd0, 1'b0, 32'h0}},
			'{0, 0, 8'h00, 32'h0, 32'h0, 0, 2352, 8'hFF, 1,
				'{cdsc_pkg::KIND_AUDIO, 5'd0, 12'd2352, 1'b0, 32'h0}},
			'{0, 1, cdsc_pkg::MODE_ONE, 32'h0, 32'h0, 0, 2352, 8'hA5, 1,
				'{cdsc_pkg::KIND_MODE1, 5'd16, 12'd2048, 1'b0, 32'h0}},
			'{0, 1, cdsc_pkg::MODE_TWO, 32'h0, 32'h0, 0, 0, 8'h00, 1,
				'{cdsc_pkg::KIND_FORM1, 5'd24, 12'd2048, 1'b0, 32'h0}},
			'{0, 1, cdsc_pkg::MODE_TWO, 32'h00200000, 32'h00200000, 0, 0, 8'h00, 1,
				'{cdsc_pkg::KIND_FORM2, 5'd24, 12'd2324, 1'b0, 32'h00200000}},
			'{0, 1, cdsc_pkg::MODE_TWO, 32'h00200000, 32'h00200001, 0, 0, 8'h00, 1,
				'{cdsc_pkg::KIND_MODE2, 5'd16, 12'd2336, 1'b0, 32'h0}},
			'{0, 1, 8'h00, 32'h0, 32'h0, 0, 0, 8'h00, 1,
				'{cdsc_pkg::KIND_INVALID, 5'd0, 12'd0, 1'b0, 32'h0}},
			'{0, 1, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 2352, 8'hFF, 1,
				'{cdsc_pkg::KIND_INVALID, 5'd0, 12'd0, 1'b0, 32'h0}},
			'{0, 1, 8'h03, 32'h12345678, 32'h12345678, 0, 1000, 8'h5A, 0, '0},
			'{1, 0, 8'h00, 32'h0, 32'h0, 0, 0, 8'h00, 1,
				'{cdsc_pkg::KIND_ZERO, 5'd0, 12'd0, 1'b0, 32'h0}},
			'{1, 0, 8'h00, 32'h0, 32'h0, 100, 101, 8'h01, 1,
				'{cdsc_pkg::KIND_AUDIO, 5'd0, 12'd101, 1'b1, 32'h0}},
			'{1, 0, 8'h00, 32'h0, 32'h0, 2351, 2352, 8'h80, 1,
				'{cdsc_pkg::KIND_AUDIO, 5'd0, 12'd2352, 1'b0, 32'h0}},
			'{1, 1, cdsc_pkg::MODE_ONE, 32'h0, 32'h0, 0, 0, 8'h00, 1,
				'{cdsc_pkg::KIND_MODE1, 5'd16, 12'd0, 1'b1, 32'h0}},
			'{1, 1, cdsc_pkg::MODE_ONE, 32'h0, 32'h0, 2000, 2352, 8'h55, 1,
				'{cdsc_pkg::KIND_MODE1, 5'd16, 12'd2048, 1'b0, 32'h0}},
			'{1, 1, cdsc_pkg::MODE_TWO, 32'h11223344, 32'h11223344, 24, 500, 8'h7F, 1,
				'{cdsc_pkg::KIND_FORM2, 5'd24, 12'd476, 1'b1, 32'h11223344}},
			'{1, 1, cdsc_pkg::MODE_TWO, 32'h01020304, 32'h01020304, 2072, 2352, 8'hFF, 1,
				'{cdsc_pkg::KIND_FORM1, 5'd24, 12'd0, 1'b1, 32'h01020304}},
			'{1, 1, cdsc_pkg::MODE_TWO, 32'hDEADBEEF, 32'hDEADBEEE, 0, 0, 8'h00, 0, '0},
			'{1, 1, cdsc_pkg::MODE_TWO, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 2352, 8'hFF, 1,
				'{cdsc_pkg::KIND_FORM2, 5'd24, 12'd2324, 1'b0, 32'hFFFFFFFF}},
			'{1, 0, 8'h00, 32'h0, 32'h0, 1, 12, 8'hFF, 0, '0}
		};

		phases = '{
			'{0, 0, 0, 10, 0},
			'{78, 0, 1, 8, 0},
			'{0, 78, 0, 10, 0},
			'{0, 0, 1, 4, 1},
			'{10, 10, 1, 8, 0},
			'{0, 0, 0, 6, 0}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle = 10;
		sink_stall = 10;
		for (r = 0; r < 19; r++) begin
			if (r == 0 || recipes[r].trim != trim_on) set_trim(recipes[r].trim);
			for (i = 0; i < SEC_N; i++)
				sec_buf[i] = (i >= recipes[r].lo && i < recipes[r].hi) ? recipes[r].fill : 8'h00;
			if (recipes[r].hdr) put_header(recipes[r].mode, recipes[r].sub_a, recipes[r].sub_b);
			plan.typed = recipes[r].typed;
			plan.want = recipes[r].want;
			plan_q.push_back(plan);
			send_sector();
		end

		for (ph = 0; ph < 6; ph++) begin
			set_trim(phases[ph].trim);
			src_idle = phases[ph].src_idle;
			sink_stall = phases[ph].sink_stall;
			if (phases[ph].hold) hold_req++;
			for (s = 0; s < phases[ph].sectors; s++) begin
				fill_random();
				plan.typed = 1'b0;
				plan.want = '0;
				plan_q.push_back(plan);
				send_sector();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
